### design/spls_pkg.sv
package spls_pkg;

	// field widths
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;

	// operation codes
	localparam logic OP_PUSH   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_PUSHED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic                key_ld;
		logic                push_wr;
		logic                scan_start;
		logic                scan_run;
		logic                hit_cap;
		logic                res_ld;
		logic [STATUS_W-1:0] res_status;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic hit;
		logic exhausted;
	} stat_t;

endpackage

### design/spls_if.sv
// request channel: operation and key
interface spls_req_if;
	import spls_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink (input valid, input operation, input key, output ready);
endinterface

// response channel: status and position
interface spls_rsp_if;
	import spls_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;

	modport source (output valid, output status, output position, input ready);
	modport sink (input valid, input status, input position, output ready);
endinterface

### design/spls_datapath.sv
module spls_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spls_pkg::cmd_t                cmd,
	input  logic [spls_pkg::KEY_W-1:0]    key,
	output spls_pkg::stat_t               stat,
	output logic [spls_pkg::STATUS_W-1:0] status,
	output logic [spls_pkg::POS_W-1:0]    position
);
	import spls_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [KEY_W-1:0] mem [DEPTH];
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    scan_idx_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] rd_data_s1;
	logic [IW-1:0]    idx_s1;
	logic             pend_s1;
	logic [POS_W-1:0] found_pos_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0] rsp_pos_q;
	logic             rd_en;

	assign rd_en = cmd.scan_run && (scan_idx_q < fill_q);

	// stack memory: push write and scan read
	always_ff @(posedge clk) begin
		if (cmd.push_wr)
			mem[fill_q[IW-1:0]] <= key;
		if (rd_en)
			rd_data_s1 <= mem[scan_idx_q[IW-1:0]];
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (cmd.push_wr)
			fill_q <= fill_q + FW'(1);
	end

	// scan pointer and compare stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
		end else if (cmd.scan_run) begin
			pend_s1 <= rd_en;
			if (rd_en)
				scan_idx_q <= scan_idx_q + FW'(1);
		end
	end

	// search key and compare stage index
	always_ff @(posedge clk) begin
		if (cmd.key_ld)
			key_q <= key;
		if (rd_en)
			idx_s1 <= scan_idx_q[IW-1:0];
		if (cmd.hit_cap)
			found_pos_q <= POS_W'(idx_s1);
	end

	// result register, position held with its status while the result waits
	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			status_q  <= cmd.res_status;
			rsp_pos_q <= (cmd.res_status == ST_FOUND) ? found_pos_q : '0;
		end
	end

	assign stat.full      = (fill_q == FW'(DEPTH));
	assign stat.hit       = pend_s1 && (rd_data_s1 == key_q);
	assign stat.exhausted = !pend_s1 && (scan_idx_q >= fill_q);

	assign status   = status_q;
	assign position = rsp_pos_q;

endmodule

### design/spls_ctrl.sv
module spls_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_operation,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  spls_pkg::stat_t stat,
	output spls_pkg::cmd_t  cmd
);
	import spls_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	logic [STATUS_W-1:0] code_q;
	logic [STATUS_W-1:0] code_d;
	logic                out_valid_q;
	logic                accept;
	logic                slot_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		code_d         = code_q;
		cmd            = '0;
		cmd.res_status = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.key_ld = 1'b1;
					if (req_operation == OP_PUSH) begin
						cmd.push_wr = !stat.full;
						code_d      = stat.full ? ST_FULL : ST_PUSHED;
						state_d     = S_RESP;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.hit_cap = 1'b1;
					code_d      = ST_FOUND;
					state_d     = S_RESP;
				end else if (stat.exhausted) begin
					code_d  = ST_NOTFOUND;
					state_d = S_RESP;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, result code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_PUSHED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (cmd.res_ld)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### design/stack_push_with_linear_search.sv
// channel | dir | payload             | transaction
// req     | in  | operation, key      | push or search request
// rsp     | out | status, position    | one result per request
//
// a push result is loaded into the output register from the response state, once
// that register is free; a search result is loaded the same way after the scan:
// the single stack memory is read one entry per cycle, lowest index first, and
// the scan stops on a match
// arst_n clears the fill count and control; the stored keys are not cleared
// the result sits in an output register, so a new request is taken while
// a result waits; a stalled result holds the next result in the controller
module stack_push_with_linear_search #(
	parameter int DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	spls_req_if.sink   req,
	spls_rsp_if.source rsp
);
	import spls_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	spls_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	spls_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key      (KEY_W'(req.key)),
		.stat     (stat),
		.status   (rsp.status),
		.position (rsp.position)
	);

`ifndef ASSERT_OFF
	// an accepted request blocks intake until its result is queued
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in work");

	// never write past the top of the stack
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !stat.full)
		else $error("push written into a full stack");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> (!rsp.valid || rsp.ready))
		else $error("result loaded over an unsent result");

	// position is zero unless the search found the key
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != ST_FOUND) |-> (rsp.position == '0))
		else $error("nonzero position on a result other than found");
`endif

endmodule
